/* hw/rtl/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the page/column lcd controller: display ram
// geometry, bus command codes, command byte decoding and the sequencer states.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // display ram geometry: 8 pages by COLUMNS columns of one byte
  localparam int unsigned COLUMNS  = 64;
  localparam int unsigned PAGES    = 8;
  localparam int unsigned RAM_DEPTH = PAGES * COLUMNS;
  localparam int unsigned ADDR_W   = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // bus access codes
  localparam logic [1:0] CMD_CTRL  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_PORTC = 2'd3;

  // control byte decoding
  localparam logic [7:0] PAGE_CMD_MASK = 8'hFC;
  localparam logic [7:0] PAGE_CMD      = 8'hB8;
  localparam logic [7:0] COL_CMD_MASK  = 8'hC0;
  localparam logic [7:0] MODE_CMD_MASK = 8'hF0;
  localparam logic [7:0] MODE_CMD      = 8'hE0;
  localparam logic [7:0] MODE_ARG_MASK = 8'h0E;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } lpc_state_e;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic       load;
    logic [7:0] data;
  } lpc_res_t;

endpackage

/* hw/rtl/lpc_if.sv */
// ----------------------------------------------------------------------------
// lpc_req_if / lpc_rsp_if
// Valid/ready channels of the lcd controller: bus accesses in, read bytes out.
// ----------------------------------------------------------------------------
interface lpc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface lpc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

/* hw/rtl/lpc_ram.sv */
// ----------------------------------------------------------------------------
// lpc_ram
// Generic synchronous ram: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpc_ram #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* hw/rtl/lpc_ctrl.sv */
// ----------------------------------------------------------------------------
// lpc_ctrl
// Access sequencer: clears the display ram after reset, decodes bus accesses,
// keeps page/column/mode registers and reads or writes the display ram.
// ----------------------------------------------------------------------------
module lpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_command_i,
  input  logic [7:0]       in_value_i,
  input  logic             slot_free_i,
  output logic             in_ready_o,
  output lpc_pkg::lpc_res_t res_o
);
  import lpc_pkg::*;

  lpc_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]        column_q, column_d;
  logic [2:0]        page_q, page_d;
  logic              rmw_q, rmw_d;
  logic              primed_q, primed_d;
  logic [2:0]        slot_q, slot_d;
  logic [1:0]        first_q, first_d;
  logic              phb_q, phb_d;
  logic              in_range_q, in_range_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              in_range;
  logic              page_cmd;
  logic [2:0]        cur_slot;

  lpc_ram #(
    .DEPTH  (RAM_DEPTH),
    .WIDTH  (8),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  assign in_range = ({1'b0, column_q} < 9'(COLUMNS));
  assign ram_addr = ADDR_W'(page_q) * ADDR_W'(COLUMNS) + ADDR_W'(column_q);
  assign page_cmd = ((in_value_i & PAGE_CMD_MASK) == PAGE_CMD);
  // a page command restarts the command history at slot zero
  assign cur_slot = page_cmd ? 3'd0 : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      column_q   <= '0;
      page_q     <= '0;
      rmw_q      <= 1'b0;
      primed_q   <= 1'b0;
      slot_q     <= '0;
      first_q    <= '0;
      phb_q      <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      column_q   <= column_d;
      page_q     <= page_d;
      rmw_q      <= rmw_d;
      primed_q   <= primed_d;
      slot_q     <= slot_d;
      first_q    <= first_d;
      phb_q      <= phb_d;
      in_range_q <= in_range_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    column_d   = column_q;
    page_d     = page_q;
    rmw_d      = rmw_q;
    primed_d   = primed_q;
    slot_d     = slot_q;
    first_d    = first_q;
    phb_d      = phb_q;
    in_range_d = in_range_q;
    ram_we     = 1'b0;
    ram_waddr  = ram_addr;
    ram_wdata  = in_value_i;
    ram_re     = 1'b0;
    in_ready_o = 1'b0;
    res_o      = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(RAM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = slot_free_i;
        if (in_valid_i && slot_free_i) begin
          case (in_command_i)
            CMD_CTRL: begin
              res_o.load = 1'b1;
              primed_d   = 1'b0;
              if (page_cmd) begin
                page_d = {phb_q, in_value_i[1:0]};
              end else if ((in_value_i & COL_CMD_MASK) == 8'h00) begin
                column_d = in_value_i;
              end else if ((in_value_i & MODE_CMD_MASK) == MODE_CMD) begin
                rmw_d = ((in_value_i & MODE_ARG_MASK) == 8'h00);
              end
              if (cur_slot == 3'd0) begin
                first_d = in_value_i[1:0];
              end
              slot_d = cur_slot + 3'd1;
            end
            CMD_WRITE: begin
              res_o.load = 1'b1;
              primed_d   = 1'b0;
              ram_we     = in_range;
              column_d   = column_q + 8'd1;
            end
            CMD_READ: begin
              // address taken from the current page/column, data next cycle
              ram_re     = 1'b1;
              in_range_d = in_range;
              if (!rmw_q && primed_q) begin
                column_d = column_q + 8'd1;
              end
              primed_d = 1'b1;
              state_d  = S_READ;
            end
            CMD_PORTC: begin
              res_o.load = 1'b1;
              phb_d      = in_value_i[2];
              page_d     = {in_value_i[2], first_q};
            end
            default: begin
              res_o.load = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        // ram data holds until the output register can take it
        if (slot_free_i) begin
          res_o.load = 1'b1;
          res_o.data = in_range_q ? ram_rdata : 8'h00;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/lcd_page_column_controller_top.sv */
// ----------------------------------------------------------------------------
// lcd_page_column_controller_top
// Page/column monochrome lcd controller with a byte-wide display ram of
// 8 pages by COLUMNS columns, driven by command, data and port-c accesses.
//
//   channel  dir  payload                    transfer
//   req_i    in   command[1:0], value[7:0]   valid & ready
//   rsp_o    out  read_data[7:0]             valid & ready
//
// every request gives exactly one response; read_data is 0 unless a data read
// control, data write and port-c accesses are answered straight from the idle state,
// data reads go through S_READ since the display ram has registered read data
// after reset the display ram is swept to zero, all 8 * COLUMNS bytes (512),
// with req_i.ready low
// the response waits in an output register; a new request is taken only while
// that register is empty or hands its transaction over in the same cycle
// ----------------------------------------------------------------------------
module lcd_page_column_controller_top (
  input logic       clk_i,
  input logic       rst_ni,
  lpc_req_if.sink   req_i,
  lpc_rsp_if.source rsp_o
);
  import lpc_pkg::*;

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       slot_free;
  lpc_res_t   res;

  assign slot_free = !out_valid_q || rsp_o.ready;

  lpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_value_i   (req_i.value),
    .slot_free_i  (slot_free),
    .in_ready_o   (req_i.ready),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_data_q <= res.data;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

endmodule

/* hw/rtl/lpc_checker.sv */
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks of the lcd controller, bound to the top level.
// ----------------------------------------------------------------------------
module lpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_command_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_data_i
);
  import lpc_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // no request is ready right after reset, when the display ram clear begins
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("request ready during ram clear");

  // non-read accesses answer 0 in the very next cycle
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_command_i != CMD_READ) |=> out_valid_i && (out_data_i == 8'h00))
    else $error("non-read access did not answer zero");

  // a data read holds off the next request for its ram cycle
  a_read_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_command_i == CMD_READ) |=> !in_ready_i)
    else $error("request taken during ram read");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled response changed");

endmodule

bind lcd_page_column_controller_top lpc_checker u_lpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_command_i (req_i.command),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_data_i   (rsp_o.read_data)
);

/* verif/lpc_access_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpc_access_checker
// Passive checker of the page/column lcd controller. It watches the request
// and response channels, predicts the read byte of every accepted bus access
// from its own shadow of the display ram and controller registers, and
// compares each response in order against the oldest prediction.
// ----------------------------------------------------------------------------
module lpc_access_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lpc_req_if   req_mon,
  lpc_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import lpc_pkg::*;

  // shadow of the controller state
  logic [7:0] shadow_ram [RAM_DEPTH];
  logic [7:0] column;
  logic [2:0] page;
  logic       rmw_on;
  logic       read_primed;
  logic [2:0] hist_slot;
  logic [1:0] first_cmd;
  logic       page_hi;

  logic [7:0] expected_bytes [$];
  int         fails;

  function automatic int ram_addr();
    return int'(page) * int'(COLUMNS) + int'(column);
  endfunction

  function automatic logic [7:0] predict_access(logic [1:0] cmd, logic [7:0] v);
    logic [7:0] rd;
    rd = 8'h00;
    case (cmd)
      CMD_CTRL: begin
        read_primed = 1'b0;
        if ((v & PAGE_CMD_MASK) == PAGE_CMD) begin
          // page command restarts the command history
          hist_slot = 3'd0;
          first_cmd = v[1:0];
          page      = {page_hi, first_cmd};
        end else if ((v & COL_CMD_MASK) == 8'h00) begin
          column = v;
        end else if ((v & MODE_CMD_MASK) == MODE_CMD) begin
          rmw_on = ((v & MODE_ARG_MASK) == 8'h00);
        end
        if (hist_slot == 3'd0) first_cmd = v[1:0];
        hist_slot = hist_slot + 3'd1;
      end
      CMD_WRITE: begin
        read_primed = 1'b0;
        if (int'(column) < int'(COLUMNS)) shadow_ram[ram_addr()] = v;
        column = column + 8'd1;
      end
      CMD_READ: begin
        if (int'(column) < int'(COLUMNS)) rd = shadow_ram[ram_addr()];
        // first read after a write or control access leaves the column in place
        if (!rmw_on && read_primed) column = column + 8'd1;
        read_primed = 1'b1;
      end
      default: begin
        page_hi = v[2];
        page    = {page_hi, first_cmd};
      end
    endcase
    return rd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(RAM_DEPTH); i++) shadow_ram[i] = 8'h00;
      column      = 8'h00;
      page        = 3'd0;
      rmw_on      = 1'b0;
      read_primed = 1'b0;
      hist_slot   = 3'd0;
      first_cmd   = 2'd0;
      page_hi     = 1'b0;
      expected_bytes.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // retire the response first: it can never belong to this cycle's request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %02h",
                   $time, rsp_mon.read_data);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_mon.read_data !== want) begin
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, want, rsp_mon.read_data);
            fails++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_bytes.push_back(predict_access(req_mon.command, req_mon.value));
      fail_count_o <= fails;
      pending_o    <= expected_bytes.size();
    end
  end

endmodule

/* verif/tb_lcd_page_column_controller_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_page_column_controller_top
// Regression of the page/column lcd controller: a directed run over the
// command decodes, column edges and read-modify-write, then random window
// accesses, long column-wrapping bursts and noise, with random gaps on the
// request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_lcd_page_column_controller_top;
  import lpc_pkg::*;

  localparam int NUM_ITEMS    = 1850;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpc_req_if req_if ();
  lpc_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent;
  int req_max_gap;
  int rsp_max_stall;

  lcd_page_column_controller_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lpc_access_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk_i);
    $display("lcd_page_column_controller_top regression: fail");
    $finish;
  end

  // valid is only lowered when a gap follows, so it never toggles within a step
  task automatic send_access(input logic [1:0] cmd, input logic [7:0] val);
    int gap;
    gap = $urandom_range(0, req_max_gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.value   <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // response side: random stall before each transaction
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rsp_max_stall);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  initial begin
    int         kind;
    int         n;
    int         next_phase;
    logic [7:0] col;
    items_sent     = 0;
    req_max_gap    = 5;
    rsp_max_stall  = 5;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_CTRL;
    req_if.value   <= 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: dummy read, column edges, page/port-c, read-modify-write
    send_access(CMD_READ, 8'h00);
    send_access(CMD_READ, 8'hFF);
    send_access(CMD_CTRL, 8'h3F);
    send_access(CMD_WRITE, 8'hFF);
    send_access(CMD_WRITE, 8'hA5);   // dropped past last column
    send_access(CMD_READ, 8'h00);    // past last column reads zero
    send_access(CMD_CTRL, 8'h00);
    send_access(CMD_WRITE, 8'h00);
    send_access(CMD_WRITE, 8'h5A);
    send_access(CMD_CTRL, 8'hBB);
    send_access(CMD_PORTC, 8'h04);
    send_access(CMD_WRITE, 8'h81);
    send_access(CMD_CTRL, 8'hE0);
    send_access(CMD_CTRL, 8'h00);
    send_access(CMD_READ, 8'h00);
    send_access(CMD_READ, 8'h00);
    send_access(CMD_READ, 8'h00);
    send_access(CMD_CTRL, 8'hEE);
    send_access(CMD_PORTC, 8'hFB);
    send_access(CMD_CTRL, 8'hFF);
    send_access(CMD_CTRL, 8'h40);
    send_access(CMD_PORTC, 8'hFF);
    send_access(CMD_WRITE, 8'h3C);
    send_access(CMD_READ, 8'h00);
    send_access(CMD_READ, 8'h00);

    next_phase = items_sent + 300;
    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= next_phase) begin
        // hold off until the response side has caught up, then re-pace
        req_if.valid <= 1'b0;
        wait_drained();
        req_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 5;
        rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 5;
        next_phase    = items_sent + 300;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // window: page, column, write burst, rewind, read back
        if ($urandom_range(0, 3) == 0) send_access(CMD_PORTC, 8'($urandom));
        send_access(CMD_CTRL, PAGE_CMD | 8'($urandom_range(0, 3)));
        col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(58, 63))
                                          : 8'($urandom_range(0, 63));
        send_access(CMD_CTRL, col);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_access(CMD_WRITE, 8'($urandom));
        send_access(CMD_CTRL, col);
        n = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) send_access(CMD_READ, 8'($urandom));
      end else if (kind < 60) begin
        // read-modify-write: reads hold the column, writes advance it
        send_access(CMD_CTRL, MODE_CMD | 8'($urandom_range(0, 1)));
        send_access(CMD_CTRL, 8'($urandom_range(0, 63)));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          send_access(CMD_READ, 8'($urandom));
          send_access(CMD_READ, 8'($urandom));
          send_access(CMD_WRITE, 8'($urandom));
        end
        send_access(CMD_CTRL, MODE_CMD | 8'($urandom_range(2, 15)));
      end else if (kind < 70) begin
        send_access(CMD_PORTC, 8'($urandom));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_access(CMD_READ, 8'($urandom));
      end else if (kind < 71) begin
        // long burst so the column can run past 255 and wrap
        send_access(CMD_CTRL, 8'($urandom_range(0, 63)));
        n = $urandom_range(200, 260);
        for (int i = 0; i < n; i++)
          send_access(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ,
                      8'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_access(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("lcd_page_column_controller_top regression: pass");
    end else begin
      $display("lcd_page_column_controller_top regression: fail");
    end
    $finish;
  end

endmodule
